[hw/rtl/stc_pkg.sv]
// Package for the source transfer controller: transaction structs, register
// indexes, reset values and status codes. No dependencies.
package stc_pkg;

    // Default width of the wrapping millisecond timers.
    localparam int STC_TIME_BITS = 32;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int STATUS_BITS    = 5;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;
    typedef logic [STATUS_BITS-1:0]    status_t;

    // Configuration register indexes.
    localparam cfg_index_t REG_FAILURE_DELAY  = 2'd0;
    localparam cfg_index_t REG_RECOVERY_DELAY = 2'd1;
    localparam cfg_index_t REG_MIN_INTERVAL   = 2'd2;

    // Configuration reset values (ms).
    localparam cfg_data_t FAILURE_DELAY_RST  = 16'd500;
    localparam cfg_data_t RECOVERY_DELAY_RST = 16'd5000;
    localparam cfg_data_t MIN_INTERVAL_RST   = 16'd3000;

    // Status codes.
    localparam status_t ST_ON_B_OK        = 5'd0;
    localparam status_t ST_B_CHECK        = 5'd1;
    localparam status_t ST_B_FAIL_TO_A    = 5'd2;
    localparam status_t ST_BOTH_BAD       = 5'd3;
    localparam status_t ST_A_BAD_TO_B     = 5'd4;
    localparam status_t ST_A_BAD_WAIT     = 5'd5;
    localparam status_t ST_B_RECOVERING   = 5'd6;
    localparam status_t ST_B_READY        = 5'd7;
    localparam status_t ST_TRANSFER_B     = 5'd8;
    localparam status_t ST_SF_B_NO_SIGNAL = 5'd9;
    localparam status_t ST_SF_B_FREQ      = 5'd10;
    localparam status_t ST_SF_B_VOLT      = 5'd11;
    localparam status_t ST_SF_A_NO_SIGNAL = 5'd12;
    localparam status_t ST_SF_A_FREQ      = 5'd13;
    localparam status_t ST_SF_A_VOLT      = 5'd14;
    localparam status_t ST_SF_PHASE_INV   = 5'd15;
    localparam status_t ST_SF_PHASE_RANGE = 5'd16;
    localparam status_t ST_SF_FREQ_DIFF   = 5'd17;
    localparam status_t ST_SF_VOLT_DIFF   = 5'd18;
    localparam status_t ST_SF_NOT_SYNC    = 5'd19;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        b_no_signal;
        logic        b_freq_bad;
        logic        b_volt_bad;
        logic        a_no_signal;
        logic        a_freq_bad;
        logic        a_volt_bad;
        logic        phase_invalid;
        logic        phase_out_of_range;
        logic        freq_diff_bad;
        logic        volt_diff_bad;
        logic        sync_ready;
    } stc_in_t;

    typedef struct packed {
        logic    drive_b;
        logic    on_b;
        status_t status_code;
    } stc_out_t;

    // Fixed-priority reason for a missing sync.
    function automatic status_t sync_fault(input stc_in_t d);
        status_t code;
        if (d.b_no_signal)             code = ST_SF_B_NO_SIGNAL;
        else if (d.b_freq_bad)         code = ST_SF_B_FREQ;
        else if (d.b_volt_bad)         code = ST_SF_B_VOLT;
        else if (d.a_no_signal)        code = ST_SF_A_NO_SIGNAL;
        else if (d.a_freq_bad)         code = ST_SF_A_FREQ;
        else if (d.a_volt_bad)         code = ST_SF_A_VOLT;
        else if (d.phase_invalid)      code = ST_SF_PHASE_INV;
        else if (d.phase_out_of_range) code = ST_SF_PHASE_RANGE;
        else if (d.freq_diff_bad)      code = ST_SF_FREQ_DIFF;
        else if (d.volt_diff_bad)      code = ST_SF_VOLT_DIFF;
        else                           code = ST_SF_NOT_SYNC;
        return code;
    endfunction

endpackage

[hw/rtl/source_transfer_controller_unit.sv]
// Source transfer controller top level: input register, decision logic,
// state and result register. Depends on stc_pkg.
//
// Static transfer switch controller for two AC sources, A preferred and B
// standby. Each input transaction carries a millisecond timestamp, the health
// flags of both sources, the sync-check flags and sync_ready; each yields
// exactly one result transaction with the drive line, the active source and
// a status code. Throughput is one transaction per clock while m_ready does
// not stall: a transaction is registered in the input register, where the
// decision (three wrapping subtract-and-compare timers plus a priority
// encoder) is evaluated, and moves to the result register at the same edge
// that updates the controller state, so the next transaction already sees
// that state. m_valid rises once the transaction is in the result register.
// A stalled m_ready holds the result register and, one transaction later,
// the input register; nothing is lost.
// Timers wrap modulo 2^TIME_BITS. Write the delay registers over cfg_* only
// while no transaction is in flight; writes to unused indexes are dropped.
module source_transfer_controller_unit
    import stc_pkg::*;
#(
    parameter int TIME_BITS = STC_TIME_BITS
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  stc_in_t    s_data,

    output logic       m_valid,
    input  logic       m_ready,
    output stc_out_t   m_data,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  cfg_data_t  cfg_data
);

    typedef logic [TIME_BITS-1:0] stamp_t;

    // Configuration registers.
    cfg_data_t failure_delay_reg;
    cfg_data_t recovery_delay_reg;
    cfg_data_t min_interval_reg;

    // Input stage.
    logic    in_valid_reg;
    stc_in_t in_data_reg;

    // Result stage.
    logic     out_valid_reg;
    stc_out_t out_data_reg;

    // Controller state.
    logic   active_is_b_reg,    active_is_b_next;
    logic   fail_timing_reg,    fail_timing_next;
    stamp_t fail_start_reg,     fail_start_next;
    logic   recover_timing_reg, recover_timing_next;
    stamp_t recover_start_reg,  recover_start_next;
    stamp_t last_transfer_reg,  last_transfer_next;
    logic   drive_line_reg,     drive_line_next;
    status_t status_next;

    logic   advance;
    stamp_t now;
    logic   b_ok, a_ok, sync;
    logic   fail_expired, recover_expired, interval_met;

    // Move a transaction from input to result register when the result slot
    // is free or being drained.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    // Zero-extend or truncate the timestamp to the timer width.
    assign now  = stamp_t'(in_data_reg.now_ms);
    assign b_ok = !(in_data_reg.b_no_signal | in_data_reg.b_freq_bad | in_data_reg.b_volt_bad);
    assign a_ok = !(in_data_reg.a_no_signal | in_data_reg.a_freq_bad | in_data_reg.a_volt_bad);
    assign sync = in_data_reg.sync_ready;

    // A timer that is not yet running starts now, so its elapsed time is 0.
    assign fail_expired = (fail_timing_reg ? stamp_t'(now - fail_start_reg) : '0)
                          >= stamp_t'(failure_delay_reg);
    assign recover_expired = (recover_timing_reg ? stamp_t'(now - recover_start_reg) : '0)
                             >= stamp_t'(recovery_delay_reg);
    assign interval_met = stamp_t'(now - last_transfer_reg) >= stamp_t'(min_interval_reg);

    always_comb begin
        active_is_b_next    = active_is_b_reg;
        fail_timing_next    = fail_timing_reg;
        fail_start_next     = fail_start_reg;
        recover_timing_next = recover_timing_reg;
        recover_start_next  = recover_start_reg;
        last_transfer_next  = last_transfer_reg;
        drive_line_next     = drive_line_reg;
        status_next         = ST_ON_B_OK;

        if (active_is_b_reg) begin
            recover_timing_next = 1'b0;
            if (!b_ok) begin
                if (!fail_timing_reg) begin
                    fail_start_next = now;
                end
                if (fail_expired) begin
                    // B fault outlasted the failure delay: fall back to A.
                    drive_line_next  = 1'b0;
                    active_is_b_next = 1'b0;
                    last_transfer_next = now;
                    status_next      = a_ok ? ST_B_FAIL_TO_A : ST_BOTH_BAD;
                    fail_timing_next = 1'b0;
                end else begin
                    // Hold the drive line while B fault is being timed.
                    fail_timing_next = 1'b1;
                    status_next      = ST_B_CHECK;
                end
            end else begin
                fail_timing_next = 1'b0;
                drive_line_next  = 1'b1;
                status_next      = ST_ON_B_OK;
            end
        end else begin
            fail_timing_next = 1'b0;
            if (!a_ok) begin
                // Recovery timer is left untouched while A is bad.
                if (b_ok && sync) begin
                    if (interval_met) begin
                        drive_line_next    = 1'b1;
                        active_is_b_next   = 1'b1;
                        last_transfer_next = now;
                        status_next        = ST_A_BAD_TO_B;
                    end else begin
                        status_next = ST_A_BAD_WAIT;
                    end
                end else begin
                    drive_line_next = 1'b0;
                    status_next     = b_ok ? sync_fault(in_data_reg) : ST_BOTH_BAD;
                end
            end else if (b_ok) begin
                recover_timing_next = 1'b1;
                if (!recover_timing_reg) begin
                    recover_start_next = now;
                end
                if (recover_expired) begin
                    if (sync) begin
                        if (interval_met) begin
                            drive_line_next    = 1'b1;
                            active_is_b_next   = 1'b1;
                            last_transfer_next = now;
                            status_next        = ST_TRANSFER_B;
                        end else begin
                            status_next = ST_B_READY;
                        end
                    end else begin
                        drive_line_next = 1'b0;
                        status_next     = sync_fault(in_data_reg);
                    end
                end else begin
                    drive_line_next = 1'b0;
                    status_next     = ST_B_RECOVERING;
                end
            end else begin
                recover_timing_next = 1'b0;
                drive_line_next     = 1'b0;
                status_next         = sync_fault(in_data_reg);
            end
        end
    end

    // Configuration writes; drop unused indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            failure_delay_reg  <= FAILURE_DELAY_RST;
            recovery_delay_reg <= RECOVERY_DELAY_RST;
            min_interval_reg   <= MIN_INTERVAL_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FAILURE_DELAY:  failure_delay_reg  <= cfg_data;
                REG_RECOVERY_DELAY: recovery_delay_reg <= cfg_data;
                REG_MIN_INTERVAL:   min_interval_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg.drive_b     <= drive_line_next;
            out_data_reg.on_b        <= active_is_b_next;
            out_data_reg.status_code <= status_next;
        end
    end

    // Controller state advances with each transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_is_b_reg    <= 1'b0;
            fail_timing_reg    <= 1'b0;
            fail_start_reg     <= '0;
            recover_timing_reg <= 1'b0;
            recover_start_reg  <= '0;
            last_transfer_reg  <= '0;
            drive_line_reg     <= 1'b0;
        end else if (advance) begin
            active_is_b_reg    <= active_is_b_next;
            fail_timing_reg    <= fail_timing_next;
            fail_start_reg     <= fail_start_next;
            recover_timing_reg <= recover_timing_next;
            recover_start_reg  <= recover_start_next;
            last_transfer_reg  <= last_transfer_next;
            drive_line_reg     <= drive_line_next;
        end
    end

endmodule

[bench/tb_source_transfer_controller_unit.sv]
`timescale 1ns / 1ps
// Self-checking bench for source_transfer_controller_unit: directed and random
// health samples against a cycle-free model of the A/B transfer decision.
// Depends on stc_pkg and the unit itself; no files, no arguments.
module tb_source_transfer_controller_unit;
    import stc_pkg::*;

    typedef logic [STC_TIME_BITS-1:0] ms_t;

    // Unused register index; writes to it must leave every delay untouched.
    localparam cfg_index_t REG_UNUSED = 2'd3;

    // Cycles with no transaction on any channel before the run is abandoned.
    // Covers the longest sender gap plus the longest result stall several times.
    localparam int WATCHDOG_LIMIT = 4000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    stc_in_t    s_data;
    logic       m_valid;
    logic       m_ready;
    stc_out_t   m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;

    source_transfer_controller_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Stimulus and scoreboard storage.
    stc_in_t  sample_backlog[$];   // health samples waiting to be driven
    stc_out_t switch_expect[$];    // predicted decisions, oldest first

    // Shadow copy of the delay registers, updated on each accepted write.
    ms_t fail_delay_ms;
    ms_t recover_delay_ms;
    ms_t switch_gap_ms;

    // Shadow copy of the controller state.
    logic on_source_b;
    logic fault_armed;
    ms_t  fault_since;
    logic recovery_armed;
    ms_t  recovery_since;
    ms_t  last_switch_ms;
    logic drive_line_q;

    int   mismatches;
    int   quiet_cycles;
    int   cycle_count;
    logic calm;           // when set, neither side inserts idle cycles
    logic in_taken;       // an input transaction completed at the last rising edge
    int   send_gap;
    int   ready_hold;

    // Stimulus time base and run shaping.
    ms_t  clock_ms;
    int   regime;
    int   run_left;

    // Clock: 20 ns period.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Mostly zero gaps, some short, a few long; none at all in a calm stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)    return 0;
        if (r < 55)  return 0;
        if (r < 90)  return $urandom_range(1, 3);
        if (r < 98)  return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // First set flag in priority order decides the sync-fault reason.
    function automatic status_t sync_reason(input stc_in_t d);
        logic [9:0] flags;
        status_t    code;
        flags = {d.b_no_signal, d.b_freq_bad, d.b_volt_bad,
                 d.a_no_signal, d.a_freq_bad, d.a_volt_bad,
                 d.phase_invalid, d.phase_out_of_range,
                 d.freq_diff_bad, d.volt_diff_bad};
        code = ST_SF_NOT_SYNC;
        // Walk from lowest to highest priority so the highest set flag wins.
        for (int k = 0; k <= 9; k++) begin
            if (flags[k]) code = status_t'(ST_SF_B_NO_SIGNAL + (9 - k));
        end
        return code;
    endfunction

    // Advance the shadow state by one sample and return the decision it yields.
    // Time differences are taken modulo the timer width.
    function automatic stc_out_t predict_switch(input stc_in_t d);
        logic     b_ok;
        logic     a_ok;
        ms_t      now;
        status_t  st;
        stc_out_t r;
        now  = d.now_ms;
        b_ok = !(d.b_no_signal || d.b_freq_bad || d.b_volt_bad);
        a_ok = !(d.a_no_signal || d.a_freq_bad || d.a_volt_bad);
        if (on_source_b) begin
            recovery_armed = 1'b0;
            if (!b_ok) begin
                if (!fault_armed) begin
                    fault_armed = 1'b1;
                    fault_since = now;
                end
                if (ms_t'(now - fault_since) >= fail_delay_ms) begin
                    drive_line_q   = 1'b0;
                    on_source_b    = 1'b0;
                    last_switch_ms = now;
                    fault_armed    = 1'b0;
                    st = a_ok ? ST_B_FAIL_TO_A : ST_BOTH_BAD;
                end else begin
                    st = ST_B_CHECK;
                end
            end else begin
                fault_armed  = 1'b0;
                drive_line_q = 1'b1;
                st = ST_ON_B_OK;
            end
        end else begin
            fault_armed = 1'b0;
            if (!a_ok) begin
                // Recovery timer is left alone while A is bad.
                if (b_ok && d.sync_ready) begin
                    if (ms_t'(now - last_switch_ms) >= switch_gap_ms) begin
                        drive_line_q   = 1'b1;
                        on_source_b    = 1'b1;
                        last_switch_ms = now;
                        st = ST_A_BAD_TO_B;
                    end else begin
                        st = ST_A_BAD_WAIT;
                    end
                end else begin
                    drive_line_q = 1'b0;
                    st = b_ok ? sync_reason(d) : ST_BOTH_BAD;
                end
            end else if (b_ok) begin
                if (!recovery_armed) begin
                    recovery_armed = 1'b1;
                    recovery_since = now;
                end
                if (ms_t'(now - recovery_since) >= recover_delay_ms) begin
                    if (d.sync_ready) begin
                        if (ms_t'(now - last_switch_ms) >= switch_gap_ms) begin
                            drive_line_q   = 1'b1;
                            on_source_b    = 1'b1;
                            last_switch_ms = now;
                            st = ST_TRANSFER_B;
                        end else begin
                            st = ST_B_READY;
                        end
                    end else begin
                        drive_line_q = 1'b0;
                        st = sync_reason(d);
                    end
                end else begin
                    drive_line_q = 1'b0;
                    st = ST_B_RECOVERING;
                end
            end else begin
                recovery_armed = 1'b0;
                drive_line_q   = 1'b0;
                st = sync_reason(d);
            end
        end
        r.drive_b     = drive_line_q;
        r.on_b        = on_source_b;
        r.status_code = st;
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [4:0] want,
                                 input logic [4:0] got);
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        mismatches++;
    endtask

    // Queue one sample: fault flags as {no_signal, freq, volt}, sync flags as
    // {phase_invalid, phase_out_of_range, freq_diff, volt_diff}.
    task automatic add_sample(input ms_t now, input logic [2:0] b, input logic [2:0] a,
                              input logic [3:0] sf, input logic sync);
        sample_backlog.push_back(stc_in_t'({now, b, a, sf, sync}));
    endtask

    // Write one register at a falling edge and hold until the transaction completes.
    task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_FAILURE_DELAY:  fail_delay_ms    = ms_t'(val);
            REG_RECOVERY_DELAY: recover_delay_ms = ms_t'(val);
            REG_MIN_INTERVAL:   switch_gap_ms    = ms_t'(val);
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every queued sample is in and every decision is out, then let
    // the pipeline settle.
    task automatic wait_idle();
        do @(posedge aclk);
        while (sample_backlog.size() != 0 || s_valid || switch_expect.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_delays(input cfg_data_t f, input cfg_data_t r, input cfg_data_t m);
        write_reg(REG_FAILURE_DELAY, f);
        write_reg(REG_RECOVERY_DELAY, r);
        write_reg(REG_MIN_INTERVAL, m);
    endtask

    // Random samples in runs of one health regime, so that the timers actually
    // expire and transfers happen; time steps scale with the largest delay.
    task automatic add_random_samples(input int count);
        int         span;
        int         r;
        ms_t        step;
        logic [2:0] b;
        logic [2:0] a;
        logic [3:0] sf;
        logic       sync;
        span = int'(fail_delay_ms);
        if (int'(recover_delay_ms) > span) span = int'(recover_delay_ms);
        if (int'(switch_gap_ms) > span)    span = int'(switch_gap_ms);
        span = span + 1;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 10)      step = '0;
            else if (r < 70) step = ms_t'($urandom_range(1, span / 8 + 1));
            else if (r < 90) step = ms_t'($urandom_range(span / 2, span + span / 4 + 1));
            else if (r < 95) step = ms_t'($urandom());
            else             step = -ms_t'($urandom_range(1, span / 4 + 1));
            clock_ms = clock_ms + step;

            if (run_left == 0) begin
                regime   = $urandom_range(0, 5);
                run_left = $urandom_range(2, 12);
            end
            run_left--;

            b    = 3'b000;
            a    = 3'b000;
            sf   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'b0000;
            sync = ($urandom_range(0, 7) != 0);
            case (regime)
                0: begin
                    // Healthy, with the odd glitch on either side.
                    if ($urandom_range(0, 9) == 0) b = 3'($urandom_range(1, 7));
                    if ($urandom_range(0, 9) == 0) a = 3'($urandom_range(1, 7));
                end
                1: a = 3'($urandom_range(1, 7));
                2: begin
                    b    = 3'($urandom_range(1, 7));
                    sync = 1'($urandom_range(0, 1));
                end
                3: begin
                    a    = 3'($urandom_range(1, 7));
                    b    = 3'($urandom_range(1, 7));
                    sync = 1'($urandom_range(0, 1));
                end
                4: begin
                    sf   = 4'($urandom_range(0, 15));
                    sync = 1'b0;
                end
                default: begin
                    b    = 3'($urandom_range(0, 7));
                    a    = 3'($urandom_range(0, 7));
                    sf   = 4'($urandom_range(0, 15));
                    sync = 1'($urandom_range(0, 1));
                end
            endcase
            add_sample(clock_ms, b, a, sf, sync);
        end
    endtask

    // Record each accepted sample and predict its decision at the same edge.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            switch_expect.push_back(predict_switch(s_data));
            in_taken = 1'b1;
        end
    end

    // Sample driver: present the next item at a falling edge once the previous
    // transaction completed, with a random gap after each one.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            in_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (sample_backlog.size() > 0) begin
                s_data  <= sample_backlog.pop_front();
                s_valid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result-side backpressure: one ready cycle, then a random stall.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            ready_hold = pick_gap();
        end
    end

    // Decision monitor: compare every completed result with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (switch_expect.size() == 0) begin
                $display("%0t ns: unexpected decision, expected none, got %p", $time, m_data);
                mismatches++;
            end else begin
                stc_out_t want;
                want = switch_expect.pop_front();
                if (m_data.drive_b !== want.drive_b)
                    flag_mismatch("drive_b", 5'(want.drive_b), 5'(m_data.drive_b));
                if (m_data.on_b !== want.on_b)
                    flag_mismatch("on_b", 5'(want.on_b), 5'(m_data.on_b));
                if (m_data.status_code !== want.status_code)
                    flag_mismatch("status_code", want.status_code, m_data.status_code);
            end
        end
    end

    // Watchdog, plus alternation between calm and gappy stretches.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count % 300 == 0) calm = ($urandom_range(0, 3) == 0);
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready) ||
                        (cfg_valid && cfg_ready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, quiet_cycles);
            $display("[source_transfer_controller_unit] ERROR");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        fail_delay_ms    = ms_t'(FAILURE_DELAY_RST);
        recover_delay_ms = ms_t'(RECOVERY_DELAY_RST);
        switch_gap_ms    = ms_t'(MIN_INTERVAL_RST);
        on_source_b      = 1'b0;
        fault_armed      = 1'b0;
        fault_since      = '0;
        recovery_armed   = 1'b0;
        recovery_since   = '0;
        last_switch_ms   = '0;
        drive_line_q     = 1'b0;

        mismatches   = 0;
        quiet_cycles = 0;
        cycle_count  = 0;
        calm         = 1'b0;
        in_taken     = 1'b0;
        send_gap     = 0;
        ready_hold   = 0;
        regime       = 0;
        run_left     = 0;

        // Directed walk under the reset delays (500 / 5000 / 3000 ms).
        // Start the recovery timer on A.
        add_sample(32'd0,    3'b000, 3'b000, 4'b0000, 1'b1);
        // A fails before the first interval has passed: wait, line held.
        add_sample(32'd100,  3'b000, 3'b100, 4'b0000, 1'b1);
        // A bad, B fine, no sync: each A-side reason, every lower flag set as well.
        add_sample(32'd200,  3'b000, 3'b011, 4'b1111, 1'b0);
        add_sample(32'd300,  3'b000, 3'b001, 4'b1111, 1'b0);
        add_sample(32'd400,  3'b000, 3'b111, 4'b1111, 1'b0);
        // A fine, B bad: B-side reasons in priority order, lower flags set in the first two.
        add_sample(32'd500,  3'b111, 3'b000, 4'b1111, 1'b1);
        add_sample(32'd600,  3'b011, 3'b000, 4'b1111, 1'b1);
        add_sample(32'd700,  3'b001, 3'b000, 4'b0000, 1'b0);
        // Both bad while on A.
        add_sample(32'd800,  3'b010, 3'b010, 4'b0000, 1'b1);
        // Restart recovery, let it expire, then walk the sync-check reasons.
        add_sample(32'd1000, 3'b000, 3'b000, 4'b0000, 1'b1);
        add_sample(32'd6000, 3'b000, 3'b000, 4'b1111, 1'b0);
        add_sample(32'd6001, 3'b000, 3'b000, 4'b0111, 1'b0);
        add_sample(32'd6002, 3'b000, 3'b000, 4'b0011, 1'b0);
        add_sample(32'd6003, 3'b000, 3'b000, 4'b0001, 1'b0);
        add_sample(32'd6004, 3'b000, 3'b000, 4'b0000, 1'b0);
        // Return transfer onto B, then B healthy.
        add_sample(32'd6005, 3'b000, 3'b000, 4'b0000, 1'b1);
        add_sample(32'd6100, 3'b000, 3'b000, 4'b0000, 1'b1);
        // B fault: checking with the line held, then fall back to A on expiry.
        add_sample(32'd6200, 3'b010, 3'b000, 4'b0000, 1'b1);
        add_sample(32'd6700, 3'b010, 3'b000, 4'b0000, 1'b1);
        // Recovery starts; time stepping back makes recovery look expired
        // while the interval since the fallback is still short.
        add_sample(32'd6800, 3'b000, 3'b000, 4'b0000, 1'b1);
        add_sample(32'd6750, 3'b000, 3'b000, 4'b0000, 1'b1);
        // A fails exactly one interval after the fallback: transfer onto B.
        add_sample(32'd9700, 3'b000, 3'b001, 4'b0000, 1'b1);
        // Fault timer across the wrap of the millisecond counter.
        add_sample(32'hFFFF_FFFF, 3'b111, 3'b111, 4'b1111, 1'b1);
        add_sample(32'd499,       3'b100, 3'b100, 4'b0000, 1'b0);

        // Hold reset, then release it at a falling edge.
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Zero delays: every timer is met at once.
        wait_idle();
        load_delays(16'd0, 16'd0, 16'd0);
        clock_ms = ms_t'($urandom());
        add_random_samples(120);

        // Longest delays.
        wait_idle();
        load_delays(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_random_samples(100);

        // Short random delays, with a dropped write to the unused index first.
        wait_idle();
        write_reg(REG_UNUSED, cfg_data_t'($urandom()));
        load_delays(cfg_data_t'($urandom_range(1, 40)), cfg_data_t'($urandom_range(1, 40)),
                    cfg_data_t'($urandom_range(1, 40)));
        add_random_samples(140);

        // Full-range random delays, written in a different order.
        wait_idle();
        write_reg(REG_MIN_INTERVAL, cfg_data_t'($urandom()));
        write_reg(REG_FAILURE_DELAY, cfg_data_t'($urandom()));
        write_reg(REG_RECOVERY_DELAY, cfg_data_t'($urandom()));
        add_random_samples(100);

        // Instant recovery against the longest transfer interval.
        wait_idle();
        load_delays(16'd10, 16'd0, 16'hFFFF);
        add_random_samples(80);

        // Short delays with the time base just below the wrap.
        wait_idle();
        load_delays(cfg_data_t'($urandom_range(0, 30)), cfg_data_t'($urandom_range(0, 30)),
                    cfg_data_t'($urandom_range(0, 30)));
        clock_ms = 32'hFFFF_FF00;
        add_random_samples(130);

        // Back to the reset values.
        wait_idle();
        load_delays(FAILURE_DELAY_RST, RECOVERY_DELAY_RST, MIN_INTERVAL_RST);
        add_random_samples(80);

        // Drain, then let the pipeline run on to show any stray result.
        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && switch_expect.size() == 0)
            $display("[source_transfer_controller_unit] OK");
        else
            $display("[source_transfer_controller_unit] ERROR");
        $finish;
    end

endmodule
